### rtl/core/otp_pkg.sv
package otp_pkg;

	localparam int TIME_W = 32;
	localparam int CMD_W = 2;
	localparam int HANDLE_IN_W = 6;
	localparam int HANDLE_OUT_W = 5;
	localparam int STATUS_W = 3;

	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd2;

	localparam logic [STATUS_W-1:0] ST_STARTED   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BADHANDLE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FIRED     = 3'd4;

	// Broadcast controls that every slot cell sees in the same cycle.
	typedef struct packed {
		logic tick_go;
		logic start_go;
		logic scan;
	} cell_ctl_t;

endpackage

### rtl/core/one_shot_timer_pool.sv
// Pool of SLOT_COUNT one-shot timers held in a row of slot cells. Start and
// cancel items are answered on the cycle after the item is accepted, and busy
// stays low, so a new item may follow at once. A tick item compares every
// active slot with now in the cycle it is taken, then a scan token walks the
// row one slot per cycle and each expired slot puts out one fired result as
// the token reaches it; busy stays high while the token walks and drops once
// no expired slot is left ahead of it. Results carry no back-pressure: each
// is shown for exactly one cycle, marked by valid, and must be taken then.
module one_shot_timer_pool #(
	parameter int SLOT_COUNT = 20
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [otp_pkg::CMD_W-1:0]        cmd,
	input  logic [otp_pkg::TIME_W-1:0]       now,
	input  logic [otp_pkg::TIME_W-1:0]       delay,
	input  logic [otp_pkg::HANDLE_IN_W-1:0]  handle,
	output logic                             valid,
	output logic [otp_pkg::STATUS_W-1:0]     status,
	output logic [otp_pkg::HANDLE_OUT_W-1:0] result_handle,
	output logic                             last
);
	import otp_pkg::*;

	logic                    accept;
	logic                    cancel_ok;
	cell_ctl_t               ctl;
	logic [TIME_W-1:0]       expiry_new;
	logic [SLOT_COUNT-1:0]   cancel_v;
	logic [SLOT_COUNT-1:0]   claim_v;
	logic [SLOT_COUNT-1:0]   emit_v;
	logic [SLOT_COUNT-1:0]   last_v;
	logic [SLOT_COUNT:0]     taken_c;
	logic [SLOT_COUNT:0]     token_c;
	logic [SLOT_COUNT:0]     later_c;
	logic                    any_claim;
	logic                    any_emit;
	logic                    any_last;
	logic [HANDLE_OUT_W-1:0] hit_handle;

	logic                    scanning_q;
	logic                    valid_q;
	logic [STATUS_W-1:0]     status_q;
	logic [HANDLE_OUT_W-1:0] handle_q;
	logic                    last_q;

	assign accept      = start & ~busy;
	assign ctl.tick_go  = accept && (cmd == CMD_TICK);
	assign ctl.start_go = accept && (cmd == CMD_START);
	assign ctl.scan     = scanning_q;
	assign cancel_ok    = (handle != '0) && (handle <= HANDLE_IN_W'(SLOT_COUNT));
	assign expiry_new   = now + delay;

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			cancel_v[i] = accept && (cmd == CMD_CANCEL) && cancel_ok &&
				(handle == HANDLE_IN_W'(i + 1));
		end
	end

	assign taken_c[0]          = 1'b0;
	assign token_c[0]          = ctl.tick_go;
	assign later_c[SLOT_COUNT] = 1'b0;

	for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
		otp_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.cancel_hit (cancel_v[g]),
			.now        (now),
			.expiry_new (expiry_new),
			.taken_in   (taken_c[g]),
			.taken_out  (taken_c[g+1]),
			.token_in   (token_c[g]),
			.token_out  (token_c[g+1]),
			.later_in   (later_c[g+1]),
			.later_out  (later_c[g]),
			.claim      (claim_v[g]),
			.emit       (emit_v[g]),
			.last_hit   (last_v[g])
		);
	end

	assign any_claim = |claim_v;
	assign any_emit  = |emit_v;
	assign any_last  = |last_v;

	// Claims and scan hits never occur in the same cycle, so one encoder serves both.
	always_comb begin
		hit_handle = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (claim_v[i] || emit_v[i]) begin
				hit_handle = hit_handle | HANDLE_OUT_W'(i + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scanning_q <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			// The scan stops once no expired slot is left ahead of the token.
			scanning_q <= ctl.tick_go | (scanning_q & later_c[0] & ~any_last);
			valid_q    <= any_emit |
				(accept && ((cmd == CMD_START) || (cmd == CMD_CANCEL)));
		end
	end

	always_ff @(posedge clk) begin
		if (any_emit) begin
			status_q <= ST_FIRED;
			handle_q <= hit_handle;
			last_q   <= any_last;
		end else if (accept) begin
			last_q <= 1'b1;
			case (cmd)
				CMD_START: begin
					status_q <= any_claim ? ST_STARTED : ST_FULL;
					handle_q <= hit_handle;
				end
				CMD_CANCEL: begin
					status_q <= cancel_ok ? ST_CANCELLED : ST_BADHANDLE;
					handle_q <= '0;
				end
				default: begin
					status_q <= status_q;
					handle_q <= handle_q;
				end
			endcase
		end
	end

	assign busy          = scanning_q;
	assign valid         = valid_q;
	assign status        = status_q;
	assign result_handle = handle_q;
	assign last          = last_q;

endmodule

### rtl/core/otp_cell.sv
module otp_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  otp_pkg::cell_ctl_t        ctl,
	input  logic                      cancel_hit,
	input  logic [otp_pkg::TIME_W-1:0] now,
	input  logic [otp_pkg::TIME_W-1:0] expiry_new,
	input  logic                      taken_in,
	output logic                      taken_out,
	input  logic                      token_in,
	output logic                      token_out,
	input  logic                      later_in,
	output logic                      later_out,
	output logic                      claim,
	output logic                      emit,
	output logic                      last_hit
);
	import otp_pkg::*;

	logic              active_q;
	logic              fire_q;
	logic              token_q;
	logic [TIME_W-1:0] expiry_q;

	// A start goes to the first free cell: every cell before it is busy.
	assign claim     = ctl.start_go & ~active_q & ~taken_in;
	assign taken_out = taken_in | ~active_q;

	assign emit      = ctl.scan & token_q & fire_q;
	assign later_out = fire_q | later_in;
	assign last_hit  = emit & ~later_in;
	assign token_out = ctl.scan & token_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			fire_q   <= 1'b0;
			token_q  <= 1'b0;
		end else begin
			token_q <= token_in;
			if (claim) begin
				active_q <= 1'b1;
			end else if (cancel_hit || emit) begin
				active_q <= 1'b0;
			end
			if (ctl.tick_go) begin
				fire_q <= active_q & (expiry_q < now);
			end else if (emit) begin
				fire_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			expiry_q <= expiry_new;
		end
	end

endmodule

### rtl/core/otp_checker.sv
module otp_checker #(
	parameter int SLOT_COUNT = 20
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic [otp_pkg::CMD_W-1:0]        cmd,
	input logic                             valid,
	input logic [otp_pkg::STATUS_W-1:0]     status,
	input logic [otp_pkg::HANDLE_OUT_W-1:0] result_handle,
	input logic                             last
);
	import otp_pkg::*;

	// A start or cancel item is answered by a single result on the next cycle.
	a_cmd_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd == CMD_START || cmd == CMD_CANCEL) |=> valid && last)
		else $error("start or cancel item not answered on the next cycle");

	// A tick item raises busy on the next cycle, holding off further items.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd == CMD_TICK |=> busy)
		else $error("busy not raised after a tick item");

	// Only fired results may come without last.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status != ST_FIRED |-> last)
		else $error("non-fired result without last");

	// Started and fired results name a real slot; the others carry no handle.
	a_handle_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> ((status == ST_STARTED || status == ST_FIRED) ?
			(result_handle != '0 &&
				32'(result_handle) <= 32'(SLOT_COUNT)) : (result_handle == '0)))
		else $error("result handle out of range");

endmodule

bind one_shot_timer_pool otp_checker #(.SLOT_COUNT(SLOT_COUNT)) u_otp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.cmd           (cmd),
	.valid         (valid),
	.status        (status),
	.result_handle (result_handle),
	.last          (last)
);
